/* src/srm_pkg.sv */
// Package for the serial register access master.
// Holds the item and result word types, the job type and the protocol codes.
// No dependencies.
package srm_pkg;

  // Input actions.
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_RX    = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_TX     = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // Transaction status codes.
  localparam logic [2:0] ST_BAD_HDR  = 3'd0;
  localparam logic [2:0] ST_WRITE_OK = 3'd1;
  localparam logic [2:0] ST_READ_OK  = 3'd2;
  localparam logic [2:0] ST_CHK_ERR  = 3'd3;
  localparam logic [2:0] ST_DEV_ERR  = 3'd4;

  // Link bytes.
  localparam logic [7:0] HDR_OK  = 8'hAA;
  localparam logic [7:0] HDR_ERR = 8'hA0;
  localparam int         WR_BIT  = 7;

  localparam int MAX_RES = 4;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] device_id;
    logic [7:0] reg_addr;
    logic [7:0] byte_count;
    logic [7:0] data_byte;
  } srm_in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] byte_value;
    logic [2:0] status;
    logic       last;
  } srm_out_t;

  // One result inside a job, before the last flag is attached.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] byte_value;
    logic [2:0] status;
  } srm_ent_t;

  // All results caused by one input word.
  typedef struct packed {
    logic [1:0]                 last_idx;
    srm_ent_t [MAX_RES-1:0]     ent;
  } srm_job_t;

  function automatic srm_ent_t srm_mk_ent(logic [1:0] kind, logic [7:0] val,
                                          logic [2:0] st);
    srm_ent_t e;
    e.kind       = kind;
    e.byte_value = val;
    e.status     = st;
    return e;
  endfunction

endpackage

/* src/serial_register_access_master_top.sv */
// Top level of the serial register access master.
// Depends on srm_pkg, srm_front, srm_queue and srm_back.
//
// Usage: the input channel (in_valid/in_ready/in_data) takes one word per
// request step: a start (header, device id, register address and, when no
// payload follows, the request checksum go out as transmit results), a write
// payload byte, or a byte received from the link. Words that do not fit the
// current transaction phase are dropped without any result.
// The result channel (out_valid/out_ready/out_data) gives transmit bytes,
// read data bytes and one status word per transaction; last marks the final
// result caused by each input word.
// An accepted word's job passes through the job queue and the sequencer's
// job register before its first result reaches the output register. The
// result sequencer emits one result per cycle while the receiver takes them,
// so a start word gives three or four results and every other word at most
// two; a good or error reply header that does not end the transaction, and
// any dropped word, give none at all. This output rate sets the pace.
// The front end accepts a word every cycle while the job queue (QDEPTH jobs)
// has room, and updates the transaction state at once.
// When the receiver stalls, the output register holds its result, the
// sequencer stops, the queue fills and then in_ready drops.
// Reset (rst_n low, synchronous) returns the phase to idle, clears the
// checksum, byte count and write flag, and empties queue and output.
module serial_register_access_master_top #(
  parameter int QDEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  srm_pkg::srm_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output srm_pkg::srm_out_t out_data
);
  import srm_pkg::*;

  srm_job_t job_w;
  srm_job_t q_data;
  logic     push;
  logic     pop;
  logic     q_full;
  logic     q_valid;

  // Front end: phase tracking and job building.
  srm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_ready (in_ready),
    .q_full   (q_full),
    .push     (push),
    .job      (job_w)
  );

  // Jobs wait here so that input and output stall independently.
  srm_queue #(
    .QDEPTH (QDEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wdata   (job_w),
    .pop     (pop),
    .rdata   (q_data),
    .full    (q_full),
    .q_valid (q_valid)
  );

  // Back end: one result per cycle into the output register unless stalled.
  srm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* src/srm_front.sv */
// Front end of the serial register access master: transaction state and
// classification of each input word into a job of up to four results.
// Depends on srm_pkg.
module srm_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  srm_pkg::srm_in_t  in_data,
  output logic              in_ready,
  input  logic              q_full,
  output logic              push,
  output srm_pkg::srm_job_t job
);
  import srm_pkg::*;

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_PAYLOAD = 3'd1;
  localparam logic [2:0] PH_HEADER  = 3'd2;
  localparam logic [2:0] PH_DATA    = 3'd3;
  localparam logic [2:0] PH_CHECK   = 3'd4;
  localparam logic [2:0] PH_ERRCODE = 3'd5;

  logic [2:0] phase_r, phase_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] left_r, left_nxt;
  logic       wr_r, wr_nxt;
  logic [2:0] n_res;
  logic [7:0] sum_hdr;
  logic [7:0] sum_pay;
  logic [7:0] left_dec;
  logic       fire;

  assign in_ready = !q_full;
  assign fire     = in_valid && in_ready;
  assign sum_hdr  = 8'(HDR_OK + in_data.device_id + in_data.reg_addr);
  assign sum_pay  = 8'(sum_r + in_data.data_byte);
  assign left_dec = 8'(left_r - 8'd1);

  always_comb begin
    phase_nxt = phase_r;
    sum_nxt   = sum_r;
    left_nxt  = left_r;
    wr_nxt    = wr_r;
    n_res     = 3'd0;
    job       = '0;
    case (in_data.action)
      ACT_START: begin
        if (phase_r == PH_IDLE) begin
          job.ent[0] = srm_mk_ent(KIND_TX, HDR_OK, ST_BAD_HDR);
          job.ent[1] = srm_mk_ent(KIND_TX, in_data.device_id, ST_BAD_HDR);
          job.ent[2] = srm_mk_ent(KIND_TX, in_data.reg_addr, ST_BAD_HDR);
          sum_nxt  = sum_hdr;
          wr_nxt   = in_data.reg_addr[WR_BIT];
          left_nxt = in_data.byte_count;
          if (in_data.reg_addr[WR_BIT] && in_data.byte_count != 8'd0) begin
            n_res     = 3'd3;
            phase_nxt = PH_PAYLOAD;
          end else begin
            job.ent[3] = srm_mk_ent(KIND_TX, sum_hdr, ST_BAD_HDR);
            n_res      = 3'd4;
            phase_nxt  = PH_HEADER;
          end
        end
      end
      ACT_WRITE: begin
        if (phase_r == PH_PAYLOAD) begin
          job.ent[0] = srm_mk_ent(KIND_TX, in_data.data_byte, ST_BAD_HDR);
          sum_nxt    = sum_pay;
          left_nxt   = left_dec;
          if (left_dec == 8'd0) begin
            job.ent[1] = srm_mk_ent(KIND_TX, sum_pay, ST_BAD_HDR);
            n_res      = 3'd2;
            phase_nxt  = PH_HEADER;
          end else begin
            n_res = 3'd1;
          end
        end
      end
      ACT_RX: begin
        case (phase_r)
          PH_HEADER: begin
            if (in_data.data_byte == HDR_OK) begin
              if (wr_r) begin
                job.ent[0] = srm_mk_ent(KIND_STATUS, 8'd0, ST_WRITE_OK);
                n_res      = 3'd1;
                phase_nxt  = PH_IDLE;
              end else begin
                sum_nxt   = HDR_OK;
                phase_nxt = (left_r == 8'd0) ? PH_CHECK : PH_DATA;
              end
            end else if (in_data.data_byte == HDR_ERR) begin
              phase_nxt = PH_ERRCODE;
            end else begin
              job.ent[0] = srm_mk_ent(KIND_STATUS, 8'd0, ST_BAD_HDR);
              n_res      = 3'd1;
              phase_nxt  = PH_IDLE;
            end
          end
          PH_DATA: begin
            job.ent[0] = srm_mk_ent(KIND_DATA, in_data.data_byte, ST_BAD_HDR);
            n_res      = 3'd1;
            sum_nxt    = sum_pay;
            left_nxt   = left_dec;
            if (left_dec == 8'd0) begin
              phase_nxt = PH_CHECK;
            end
          end
          PH_CHECK: begin
            job.ent[0] = srm_mk_ent(KIND_STATUS, 8'd0,
                           (in_data.data_byte == sum_r) ? ST_READ_OK : ST_CHK_ERR);
            n_res      = 3'd1;
            phase_nxt  = PH_IDLE;
          end
          PH_ERRCODE: begin
            job.ent[0] = srm_mk_ent(KIND_STATUS, in_data.data_byte, ST_DEV_ERR);
            n_res      = 3'd1;
            phase_nxt  = PH_IDLE;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
    job.last_idx = 2'(n_res - 3'd1);
  end

  assign push = fire && (n_res != 3'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      sum_r   <= 8'd0;
      left_r  <= 8'd0;
      wr_r    <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      sum_r   <= sum_nxt;
      left_r  <= left_nxt;
      wr_r    <= wr_nxt;
    end
  end

`ifndef SYNTHESIS
  a_payload_due: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> wr_r && left_r != 8'd0)
    else $error("payload phase without a pending write byte");
  a_data_is_read: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> !wr_r && left_r != 8'd0)
    else $error("read data phase on a write or with no bytes left");
  a_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    fire && phase_r == PH_IDLE && in_data.action == ACT_START |-> push && n_res >= 3'd3)
    else $error("start word in idle produced too few transmit bytes");
`endif

endmodule

/* src/srm_queue.sv */
// Short job queue between the front end and the result sequencer.
// Depends on srm_pkg.
module srm_queue #(
  parameter int QDEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  srm_pkg::srm_job_t wdata,
  input  logic              pop,
  output srm_pkg::srm_job_t rdata,
  output logic              full,
  output logic              q_valid
);
  import srm_pkg::*;

  localparam int PW = $clog2(QDEPTH);
  localparam int CW = $clog2(QDEPTH + 1);

  srm_job_t        mem [QDEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   cnt_r;
  logic            do_pop;

  assign full    = cnt_r == CW'(QDEPTH);
  assign q_valid = cnt_r != '0;
  assign rdata   = mem[rd_ptr_r];
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QDEPTH - 1)) ? '0 : PW'(wr_ptr_r + 1'b1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QDEPTH - 1)) ? '0 : PW'(rd_ptr_r + 1'b1);
      end
      if (push && !do_pop) begin
        cnt_r <= CW'(cnt_r + 1'b1);
      end else if (do_pop && !push) begin
        cnt_r <= CW'(cnt_r - 1'b1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full || do_pop)
    else $error("job pushed into a full queue");
  a_ptr_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == '0 |-> wr_ptr_r == rd_ptr_r)
    else $error("queue empty with pointers apart");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(QDEPTH))
    else $error("queue count beyond depth");
`endif

endmodule

/* src/srm_back.sv */
// Result sequencer: emits the results of each queued job one per cycle
// while not stalled into the output register, marking the final one.
// Depends on srm_pkg.
module srm_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  srm_pkg::srm_job_t q_data,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output srm_pkg::srm_out_t out_data
);
  import srm_pkg::*;

  srm_job_t   cur_r;
  logic [1:0] idx_r;
  logic       busy_r;
  srm_out_t   out_r;
  logic       out_valid_r;
  logic       adv;
  logic       at_last;
  srm_ent_t   sel;

  assign adv     = !out_valid_r || out_ready;
  assign at_last = idx_r == cur_r.last_idx;
  assign sel     = cur_r.ent[idx_r];
  assign pop     = q_valid && (!busy_r || (adv && at_last));

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= q_data;
    end
    if (adv && busy_r) begin
      out_r.kind       <= sel.kind;
      out_r.byte_value <= sel.byte_value;
      out_r.status     <= sel.status;
      out_r.last       <= at_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        out_valid_r <= busy_r;
        if (busy_r) begin
          if (at_last) begin
            busy_r <= 1'b0;
          end else begin
            idx_r <= 2'(idx_r + 2'd1);
          end
        end
      end
      if (pop) begin
        busy_r <= 1'b1;
        idx_r  <= 2'd0;
      end
    end
  end

endmodule

/* bench/serial_register_access_master_top_tb.sv */
// Self-checking testbench for serial_register_access_master_top.
// Depends on srm_pkg for the word types and protocol codes, and on the RTL under src.
// Expected results come from a behavioral model of the link master kept inside the bench.
`timescale 1ns / 1ps

module serial_register_access_master_top_tb;
  import srm_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int GAP_MAX        = 8;
  // Far above the longest quiet stretch of a correct run, which is one sender
  // gap or a few receiver stalls plus the pipeline latency.
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 16;
  localparam int ITEM_TARGET    = 420;
  localparam int PRINT_LIMIT    = 40;

  // Action code that the block never uses; such words must be dropped.
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  // Status field value carried by transmit and read data results.
  localparam logic [2:0] ST_NONE    = 3'd0;

  // Transaction phases of the link master, as tracked by the bench model.
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_PAYLOAD,
    PH_HEADER,
    PH_DATA,
    PH_CHECK,
    PH_ERRCODE
  } link_phase_e;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  srm_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  srm_out_t out_data;

  // Model state of the link master.
  link_phase_e ph      = PH_IDLE;
  logic [7:0]  run_sum = 8'h00;
  logic [7:0]  left    = 8'h00;
  logic        wr_flag = 1'b0;

  // Results the block still owes, oldest first.
  srm_out_t    due_results [$];
  srm_out_t    want;

  int unsigned err_cnt      = 0;
  int unsigned words_sent   = 0;
  int unsigned rx_hold      = 0;
  int unsigned stuck_cycles = 0;
  // When set, neither side inserts idle cycles.
  logic        no_gaps      = 1'b0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  serial_register_access_master_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  function automatic srm_out_t mk_res(logic [1:0] kind, logic [7:0] val, logic [2:0] st);
    srm_out_t r;
    r.kind       = kind;
    r.byte_value = val;
    r.status     = st;
    r.last       = 1'b0;
    return r;
  endfunction

  // Fields that the action does not use still get random values, so that the
  // block is shown to ignore them.
  function automatic srm_in_t rand_word(logic [1:0] act);
    srm_in_t w;
    w.action     = act;
    w.device_id  = 8'($urandom);
    w.reg_addr   = 8'($urandom);
    w.byte_count = 8'($urandom);
    w.data_byte  = 8'($urandom);
    return w;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int exp_v);
    err_cnt++;
    if (err_cnt <= PRINT_LIMIT) begin
      $display("%0t ns: mismatch in %s: got 'h%0h, expected 'h%0h", $time, what, got, exp_v);
    end
  endtask

  // Advances the model by one accepted word and queues every result it causes.
  // The request checksum covers every byte transmitted before it; the reply
  // checksum is seeded with the good header and covers the read data bytes.
  task automatic compute_link_results(input srm_in_t w);
    srm_out_t res [MAX_RES];
    int       n;
    n = 0;
    if (w.action == ACT_START && ph == PH_IDLE) begin
      run_sum = HDR_OK + w.device_id + w.reg_addr;
      res[0]  = mk_res(KIND_TX, HDR_OK, ST_NONE);
      res[1]  = mk_res(KIND_TX, w.device_id, ST_NONE);
      res[2]  = mk_res(KIND_TX, w.reg_addr, ST_NONE);
      n       = 3;
      wr_flag = w.reg_addr[WR_BIT];
      left    = w.byte_count;
      if (wr_flag && left != 8'd0) begin
        ph = PH_PAYLOAD;
      end else begin
        // No payload follows, so the checksum goes out with the start word.
        res[3] = mk_res(KIND_TX, run_sum, ST_NONE);
        n      = 4;
        ph     = PH_HEADER;
      end
    end else if (w.action == ACT_WRITE && ph == PH_PAYLOAD) begin
      run_sum = run_sum + w.data_byte;
      res[0]  = mk_res(KIND_TX, w.data_byte, ST_NONE);
      n       = 1;
      left    = left - 8'd1;
      if (left == 8'd0) begin
        res[1] = mk_res(KIND_TX, run_sum, ST_NONE);
        n      = 2;
        ph     = PH_HEADER;
      end
    end else if (w.action == ACT_RX) begin
      case (ph)
        PH_HEADER: begin
          if (w.data_byte == HDR_OK) begin
            if (wr_flag) begin
              res[0] = mk_res(KIND_STATUS, 8'h00, ST_WRITE_OK);
              n      = 1;
              ph     = PH_IDLE;
            end else begin
              run_sum = HDR_OK;
              ph      = (left == 8'd0) ? PH_CHECK : PH_DATA;
            end
          end else if (w.data_byte == HDR_ERR) begin
            ph = PH_ERRCODE;
          end else begin
            res[0] = mk_res(KIND_STATUS, 8'h00, ST_BAD_HDR);
            n      = 1;
            ph     = PH_IDLE;
          end
        end
        PH_DATA: begin
          run_sum = run_sum + w.data_byte;
          res[0]  = mk_res(KIND_DATA, w.data_byte, ST_NONE);
          n       = 1;
          left    = left - 8'd1;
          if (left == 8'd0) ph = PH_CHECK;
        end
        PH_CHECK: begin
          res[0] = mk_res(KIND_STATUS, 8'h00,
                          (w.data_byte == run_sum) ? ST_READ_OK : ST_CHK_ERR);
          n      = 1;
          ph     = PH_IDLE;
        end
        PH_ERRCODE: begin
          res[0] = mk_res(KIND_STATUS, w.data_byte, ST_DEV_ERR);
          n      = 1;
          ph     = PH_IDLE;
        end
        default: begin
        end
      endcase
    end
    if (n > 0) res[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) due_results.push_back(res[i]);
  endtask

  // Offers one word after a random gap and returns at the edge where it is
  // accepted. Valid is only lowered when a gap follows, so a back-to-back word
  // never sees valid dropped and raised in the same step.
  task automatic send_word(input srm_in_t w);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, GAP_MAX);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    compute_link_results(w);
  endtask

  task automatic send_start(input logic [7:0] dev, input logic [7:0] addr,
                            input logic [7:0] cnt);
    srm_in_t w;
    w            = rand_word(ACT_START);
    w.device_id  = dev;
    w.reg_addr   = addr;
    w.byte_count = cnt;
    send_word(w);
  endtask

  task automatic send_payload(input logic [7:0] b);
    srm_in_t w;
    w           = rand_word(ACT_WRITE);
    w.data_byte = b;
    send_word(w);
  endtask

  task automatic send_rx(input logic [7:0] b);
    srm_in_t w;
    w           = rand_word(ACT_RX);
    w.data_byte = b;
    send_word(w);
  endtask

  // Now and then slips in a word that cannot fit the current phase. The model
  // phase picks the kind, so the surrounding transaction is never disturbed.
  task automatic maybe_send_stray();
    srm_in_t w;
    if ($urandom_range(0, 9) != 0) return;
    w = rand_word(ACT_UNUSED);
    case ($urandom_range(0, 3))
      1: if (ph != PH_IDLE) w.action = ACT_START;
      2: if (ph != PH_PAYLOAD) w.action = ACT_WRITE;
      3: if (ph == PH_IDLE || ph == PH_PAYLOAD) w.action = ACT_RX;
      default: begin
      end
    endcase
    send_word(w);
  endtask

  // Zero-length write answered with a bad header, then a three-byte write
  // with extreme payload values and a good reply.
  task automatic test_write_paths();
    send_start(8'h00, 8'h80, 8'd0);
    send_rx(8'h00);
    send_start(8'hFF, 8'hFF, 8'd3);
    send_payload(8'h00);
    send_payload(8'hFF);
    send_payload(8'h5A);
    send_rx(HDR_OK);
  endtask

  // Zero-length read, a read whose reply checksum wraps, a read with a wrong
  // checksum, and a device error reply with code zero.
  task automatic test_read_paths();
    send_start(8'h01, 8'h00, 8'd0);
    send_rx(HDR_OK);
    send_rx(HDR_OK);
    send_start(8'hFF, 8'h7F, 8'd2);
    send_rx(HDR_OK);
    send_rx(8'hFF);
    send_rx(8'h01);
    send_rx(8'hAA);
    send_start(8'h3C, 8'h11, 8'd1);
    send_rx(HDR_OK);
    send_rx(8'h00);
    send_rx(8'h55);
    send_start(8'hC0, 8'h22, 8'd0);
    send_rx(HDR_ERR);
    send_rx(8'h00);
  endtask

  // Words out of place, sent back to back: none of them may cause a result
  // or change the transaction in progress.
  task automatic test_stray_words();
    no_gaps = 1'b1;
    send_rx(HDR_OK);
    send_payload(8'hC3);
    send_word(rand_word(ACT_UNUSED));
    send_start(8'h5A, 8'h80, 8'd1);
    send_rx(HDR_OK);
    send_start(8'h00, 8'h00, 8'd0);
    send_payload(8'h10);
    send_payload(8'h20);
    send_rx(HDR_OK);
    no_gaps = 1'b0;
  endtask

  // The longest write the count field allows, with a device error reply.
  task automatic test_max_length_write();
    send_start(8'($urandom), 8'hA5, 8'd255);
    for (int i = 0; i < 255; i++) send_payload(8'($urandom));
    send_rx(HDR_ERR);
    send_rx(8'hFF);
  endtask

  // Mostly well-formed transactions with random content; some replies carry
  // a wrong checksum, an error header or a bad header, and stray words are
  // mixed in throughout.
  task automatic test_random_traffic();
    int unsigned sel;
    logic        wr;
    logic [7:0]  cnt;
    logic [7:0]  sum;
    logic [7:0]  b;
    logic [7:0]  hdr;
    while (words_sent < ITEM_TARGET) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      wr      = 1'($urandom);
      sel     = $urandom_range(0, 99);
      if (sel < 3) cnt = 8'($urandom_range(128, 255));
      else if (sel < 15) cnt = 8'($urandom_range(8, 40));
      else cnt = 8'($urandom_range(0, 5));
      maybe_send_stray();
      send_start(8'($urandom), {wr, 7'($urandom)}, cnt);
      if (wr) begin
        for (int i = 0; i < cnt; i++) begin
          maybe_send_stray();
          send_payload(8'($urandom));
        end
      end
      maybe_send_stray();
      sel = $urandom_range(0, 99);
      if (sel < 80) begin
        send_rx(HDR_OK);
        if (!wr) begin
          sum = HDR_OK;
          for (int i = 0; i < cnt; i++) begin
            b   = 8'($urandom);
            sum = sum + b;
            maybe_send_stray();
            send_rx(b);
          end
          maybe_send_stray();
          send_rx(($urandom_range(0, 7) == 0) ? 8'($urandom) : sum);
        end
      end else if (sel < 90) begin
        send_rx(HDR_ERR);
        maybe_send_stray();
        send_rx(8'($urandom));
      end else begin
        do hdr = 8'($urandom); while (hdr == HDR_OK || hdr == HDR_ERR);
        send_rx(hdr);
      end
    end
    no_gaps = 1'b0;
  endtask

  // Result side: every accepted word is compared field by field with the
  // oldest expected result. After each accepted word the receiver draws a
  // random stall length, zero while no_gaps is set; a zero keeps ready high.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_hold = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          report_mismatch("result word with nothing due", out_data, 0);
        end else begin
          want = due_results.pop_front();
          if (out_data.kind != want.kind) begin
            report_mismatch("kind", out_data.kind, want.kind);
          end
          if (out_data.byte_value != want.byte_value) begin
            report_mismatch("byte_value", out_data.byte_value, want.byte_value);
          end
          if (out_data.status != want.status) begin
            report_mismatch("status", out_data.status, want.status);
          end
          if (out_data.last != want.last) begin
            report_mismatch("last", out_data.last, want.last);
          end
        end
        rx_hold = no_gaps ? 0 : $urandom_range(0, GAP_MAX);
      end else if (rx_hold != 0) begin
        rx_hold = rx_hold - 1;
      end
      out_ready <= (rx_hold == 0);
    end
  end

  // Watchdog: a run that goes too long without any word moving on either
  // channel has hung, including one where expected results never arrive.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stuck_cycles <= 0;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Test sequence: reset once, directed cases, the long write, random
  // traffic, then wait for every expected result plus a short drain window
  // in which any extra result would still be caught.
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_write_paths();
    test_read_paths();
    test_stray_words();
    test_max_length_write();
    test_random_traffic();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
src/srm_pkg.sv
src/srm_front.sv
src/srm_queue.sv
src/srm_back.sv
src/serial_register_access_master_top.sv
bench/serial_register_access_master_top_tb.sv
